FILE: sv/tlv_stream_length_validator_macros.svh
// Assertion macros for the TLV stream length validator.
// Included by tlvslv_walker, the only RTL file that carries concurrent checks; no other dependencies.
`ifndef TLV_STREAM_LENGTH_VALIDATOR_MACROS_SVH
`define TLV_STREAM_LENGTH_VALIDATOR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TLVSLV_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define TLVSLV_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TLVSLV_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define TLVSLV_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: sv/tlvslv_pkg.sv
// Shared types and constants for the TLV stream length validator.
// No dependencies.
package tlvslv_pkg;

    localparam int LENGTH_WIDTH_DEF     = 32;
    localparam int MAX_LENGTH_BYTES_DEF = 4;

    localparam logic [7:0] HDR_TAG      = 8'hdf;
    localparam logic [7:0] HDR_VERSION  = 8'h80;
    localparam logic [7:0] LEN_LOW_MASK = 8'h7f;

    localparam logic [2:0] ERR_OK      = 3'd0;
    localparam logic [2:0] ERR_TAG     = 3'd1;
    localparam logic [2:0] ERR_VERSION = 3'd2;
    localparam logic [2:0] ERR_OVERRUN = 3'd3;
    localparam logic [2:0] ERR_TRUNC   = 3'd4;
    localparam logic [2:0] ERR_WIDE    = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } in_item_t;

    typedef struct packed {
        logic       is_valid;
        logic [2:0] error_code;
    } out_item_t;

endpackage

FILE: sv/tlvslv_in_stage.sv
// Input register for the byte stream.
// Depends on tlvslv_pkg.
module tlvslv_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tlvslv_pkg::in_item_t s_data,
    input  logic                take,
    output logic                in_valid,
    output tlvslv_pkg::in_item_t in_item
);

    logic                 valid_reg;
    tlvslv_pkg::in_item_t item_reg;

    // refill in the same cycle the walker drains the held item
    assign s_ready  = !valid_reg || take;
    assign in_valid = valid_reg;
    assign in_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

endmodule

FILE: sv/tlvslv_walker.sv
// Header check, length decode and component walk, with the result register.
// Depends on tlvslv_pkg and tlv_stream_length_validator_macros.svh.
`include "tlv_stream_length_validator_macros.svh"

module tlvslv_walker #(
    parameter int LENGTH_WIDTH     = tlvslv_pkg::LENGTH_WIDTH_DEF,
    parameter int MAX_LENGTH_BYTES = tlvslv_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  tlvslv_pkg::in_item_t  in_item,
    output logic                  take,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tlvslv_pkg::out_item_t m_data
);

    localparam int LW    = LENGTH_WIDTH;
    localparam int LBL_W = (MAX_LENGTH_BYTES < 2) ? 1 : $clog2(MAX_LENGTH_BYTES + 1);

    typedef enum logic [3:0] {
        PH_TAG0, PH_VER, PH_SKIP, PH_TOTLEN, PH_TOTLONG,
        PH_CTAG, PH_CLEN, PH_CLONG, PH_CDATA, PH_DONE
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [LW-1:0]      br_reg, br_next;
    logic [LW-1:0]      acc_reg, acc_next;
    logic [LBL_W-1:0]   lbl_reg, lbl_next;
    logic               m_valid_reg;
    tlvslv_pkg::out_item_t m_data_reg;

    logic [7:0]         in_byte;
    logic               last;
    logic [LW+7:0]      acc_cat;
    logic [LW-1:0]      acc_shifted;
    logic               acc_full;
    logic [LW-1:0]      br_dec, acc_dec;
    logic [LBL_W-1:0]   lbl_dec;
    logic [7:0]         cnt_full;
    logic [6:0]         cnt;
    logic               long_bad;
    logic [LW-1:0]      walk_total;
    logic [LW-1:0]      cl_len;
    logic               verdict;
    logic [2:0]         code;
    logic               res_load;

    assign in_byte     = in_item.data_byte;
    assign last        = in_item.end_of_buffer;
    assign acc_cat     = {acc_reg, in_byte};
    assign acc_shifted = acc_cat[LW-1:0];
    // pushing a byte would drop set bits off the top
    assign acc_full    = acc_reg[LW-1 -: 8] != 8'd0;
    assign br_dec      = br_reg - LW'(1);
    assign acc_dec     = acc_reg - LW'(1);
    assign lbl_dec     = lbl_reg - LBL_W'(1);
    assign cnt_full    = in_byte & tlvslv_pkg::LEN_LOW_MASK;
    assign cnt         = cnt_full[6:0];
    assign long_bad    = (cnt == 7'd0) || (cnt > 7'(MAX_LENGTH_BYTES));
    assign walk_total  = (phase_reg == PH_TOTLONG) ? acc_shifted : LW'(in_byte[6:0]);
    assign cl_len      = (phase_reg == PH_CLONG) ? acc_shifted : LW'(in_byte[6:0]);

    assign take    = in_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        phase_next = phase_reg;
        br_next    = br_reg;
        acc_next   = acc_reg;
        lbl_next   = lbl_reg;
        verdict    = 1'b0;
        code       = tlvslv_pkg::ERR_OK;
        res_load   = 1'b0;

        unique case (phase_reg)
            PH_TAG0: begin
                if (in_byte != tlvslv_pkg::HDR_TAG) begin
                    verdict = 1'b1;
                    code    = tlvslv_pkg::ERR_TAG;
                end else begin
                    phase_next = PH_VER;
                end
            end
            PH_VER: begin
                if (in_byte != tlvslv_pkg::HDR_VERSION) begin
                    verdict = 1'b1;
                    code    = tlvslv_pkg::ERR_VERSION;
                end else begin
                    phase_next = PH_SKIP;
                end
            end
            PH_SKIP: begin
                phase_next = PH_TOTLEN;
            end
            PH_TOTLEN: begin
                if (in_byte[7]) begin
                    if (long_bad) begin
                        verdict = 1'b1;
                        code    = tlvslv_pkg::ERR_WIDE;
                    end else begin
                        acc_next   = '0;
                        lbl_next   = cnt[LBL_W-1:0];
                        phase_next = PH_TOTLONG;
                    end
                end else if (walk_total == '0) begin
                    verdict = 1'b1;
                end else begin
                    br_next    = walk_total;
                    phase_next = PH_CTAG;
                end
            end
            PH_TOTLONG: begin
                if (acc_full) begin
                    verdict = 1'b1;
                    code    = tlvslv_pkg::ERR_WIDE;
                end else begin
                    acc_next = acc_shifted;
                    lbl_next = lbl_dec;
                    if (lbl_dec == '0) begin
                        if (walk_total == '0) begin
                            verdict = 1'b1;
                        end else begin
                            br_next    = walk_total;
                            phase_next = PH_CTAG;
                        end
                    end
                end
            end
            PH_CTAG: begin
                br_next = br_dec;
                if (br_dec == '0) begin
                    verdict = 1'b1;
                    code    = tlvslv_pkg::ERR_OVERRUN;
                end else begin
                    phase_next = PH_CLEN;
                end
            end
            PH_CLEN: begin
                br_next = br_dec;
                if (in_byte[7]) begin
                    if (long_bad) begin
                        verdict = 1'b1;
                        code    = tlvslv_pkg::ERR_WIDE;
                    end else begin
                        acc_next = '0;
                        lbl_next = cnt[LBL_W-1:0];
                        if (br_dec < LW'(cnt)) begin
                            verdict = 1'b1;
                            code    = tlvslv_pkg::ERR_OVERRUN;
                        end else begin
                            phase_next = PH_CLONG;
                        end
                    end
                end else if (cl_len > br_dec) begin
                    verdict = 1'b1;
                    code    = tlvslv_pkg::ERR_OVERRUN;
                end else if (cl_len == '0) begin
                    if (br_dec == '0) begin
                        verdict = 1'b1;
                    end else begin
                        phase_next = PH_CTAG;
                    end
                end else begin
                    acc_next   = cl_len;
                    phase_next = PH_CDATA;
                end
            end
            PH_CLONG: begin
                if (acc_full) begin
                    verdict = 1'b1;
                    code    = tlvslv_pkg::ERR_WIDE;
                end else begin
                    br_next  = br_dec;
                    acc_next = acc_shifted;
                    lbl_next = lbl_dec;
                    if (lbl_dec == '0) begin
                        if (cl_len > br_dec) begin
                            verdict = 1'b1;
                            code    = tlvslv_pkg::ERR_OVERRUN;
                        end else if (cl_len == '0) begin
                            if (br_dec == '0) begin
                                verdict = 1'b1;
                            end else begin
                                phase_next = PH_CTAG;
                            end
                        end else begin
                            phase_next = PH_CDATA;
                        end
                    end
                end
            end
            PH_CDATA: begin
                br_next  = br_dec;
                acc_next = acc_dec;
                if (acc_dec == '0) begin
                    if (br_dec == '0) begin
                        verdict = 1'b1;
                    end else begin
                        phase_next = PH_CTAG;
                    end
                end
            end
            PH_DONE: begin
                // bytes after a verdict are dropped until end of buffer
            end
            default: begin
                phase_next = PH_DONE;
            end
        endcase

        if (verdict) begin
            phase_next = PH_DONE;
            res_load   = 1'b1;
        end else if (last && phase_reg != PH_DONE) begin
            res_load = 1'b1;
            code     = tlvslv_pkg::ERR_TRUNC;
        end
        if (last) begin
            phase_next = PH_TAG0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_TAG0;
            m_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                phase_reg <= phase_next;
                br_reg    <= br_next;
                acc_reg   <= acc_next;
                lbl_reg   <= lbl_next;
            end
            if (take && res_load) begin
                m_valid_reg           <= 1'b1;
                m_data_reg.is_valid   <= (code == tlvslv_pkg::ERR_OK);
                m_data_reg.error_code <= code;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    `TLVSLV_ASSERT_IMP(a_valid_iff_ok, aclk, aresetn, m_valid_reg, m_data_reg.is_valid == (m_data_reg.error_code == tlvslv_pkg::ERR_OK), "is_valid disagrees with error_code")
    `TLVSLV_ASSERT_IMP(a_code_range, aclk, aresetn, m_valid_reg, m_data_reg.error_code <= tlvslv_pkg::ERR_WIDE, "error_code out of range")
    `TLVSLV_ASSERT_NXT(a_last_restarts, aclk, aresetn, take && last, phase_reg == PH_TAG0, "end of buffer did not restart the parser")
    `TLVSLV_ASSERT_IMP(a_done_silent, aclk, aresetn, take && phase_reg == PH_DONE, !res_load, "second verdict for one stream")
    `TLVSLV_ASSERT_IMP(a_long_count, aclk, aresetn, phase_reg == PH_TOTLONG || phase_reg == PH_CLONG, lbl_reg != '0, "long-form byte count is zero mid-field")

endmodule

FILE: sv/tlv_stream_length_validator.sv
// Validates a tagged, length-prefixed byte stream and reports one verdict per stream.
// Takes one byte per clock: each item passes from the input register through the
// parser's next-state logic into the result register, so a verdict reaches m_valid
// through both registers in that order, and the sustained rate is one byte per cycle
// while the result side keeps up. A verdict that is not taken holds the walker; the
// input register takes at most one more byte.
// Depends on tlvslv_pkg, tlvslv_in_stage and tlvslv_walker.
module tlv_stream_length_validator #(
    parameter int LENGTH_WIDTH     = tlvslv_pkg::LENGTH_WIDTH_DEF,
    parameter int MAX_LENGTH_BYTES = tlvslv_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tlvslv_pkg::in_item_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tlvslv_pkg::out_item_t m_data
);

    logic                 take;
    logic                 in_valid;
    tlvslv_pkg::in_item_t in_item;

    tlvslv_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .take     (take),
        .in_valid (in_valid),
        .in_item  (in_item)
    );

    tlvslv_walker #(
        .LENGTH_WIDTH     (LENGTH_WIDTH),
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_walker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_valid),
        .in_item  (in_item),
        .take     (take),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

FILE: dv/tlv_stream_length_validator_tb.sv
// Testbench for tlv_stream_length_validator: byte streams in, one verdict per stream out.
// A cycle-free model of the stream walker predicts every verdict and checks it in order.
// Depends on tlvslv_pkg and the RTL of tlv_stream_length_validator.
`timescale 1ns / 1ps

module tlv_stream_length_validator_tb;

    localparam int          LW           = tlvslv_pkg::LENGTH_WIDTH_DEF;
    localparam int          MLB          = tlvslv_pkg::MAX_LENGTH_BYTES_DEF;
    localparam logic [7:0]  LEN_LONG_BIT = 8'h80;
    localparam int          RANDOM_ITEMS = 1750;
    localparam int          HOLD_AFTER   = 500;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          IDLE_LIMIT   = 3000;
    localparam int          DRAIN_CYCLES = 20;

    typedef enum logic [3:0] {
        WAIT_TAG, WAIT_VERSION, SKIP_BYTE, TOTAL_LEN, TOTAL_LONG,
        COMP_TAG, COMP_LEN, COMP_LONG, COMP_DATA, FINISHED
    } walk_phase_t;

    typedef enum {SINK_OPEN, SINK_COIN, SINK_PULSE, SINK_TRICKLE} sink_mode_t;

    typedef logic [7:0] octet_q_t[$];

    // Walks the stream byte by byte and keeps the verdicts still owed by the block.
    class verdict_tracker_t;
        walk_phase_t             phase;
        logic [LW-1:0]           remaining;
        logic [LW-1:0]           acc;
        int unsigned             len_left;
        bit                      verdict_done;
        logic [2:0]              verdict;
        tlvslv_pkg::out_item_t   owed_verdicts[$];
        int unsigned             faults;

        function new();
            faults = 0;
            restart();
        endfunction

        function void restart();
            phase        = WAIT_TAG;
            remaining    = '0;
            acc          = '0;
            len_left     = 0;
            verdict_done = 1'b0;
            verdict      = tlvslv_pkg::ERR_OK;
        endfunction

        function void settle(logic [2:0] code);
            verdict_done = 1'b1;
            verdict      = code;
            phase        = FINISHED;
        endfunction

        function bit open_long(logic [7:0] b);
            logic [7:0] n;
            n = b & tlvslv_pkg::LEN_LOW_MASK;
            if (n == 0 || n > MLB) begin
                settle(tlvslv_pkg::ERR_WIDE);
                return 1'b0;
            end
            acc      = '0;
            len_left = {24'd0, n};
            return 1'b1;
        endfunction

        function bit shift_in(logic [LW-1:0] v);
            if ((acc >> (LW - 8)) != 0)
                return 1'b0;
            acc = (acc << 8) | v;
            return 1'b1;
        endfunction

        function void begin_walk(logic [LW-1:0] total);
            remaining = total;
            if (remaining == 0)
                settle(tlvslv_pkg::ERR_OK);
            else
                phase = COMP_TAG;
        endfunction

        function void close_len(logic [LW-1:0] len);
            if (len > remaining) begin
                settle(tlvslv_pkg::ERR_OVERRUN);
            end else if (len == 0) begin
                if (remaining == 0)
                    settle(tlvslv_pkg::ERR_OK);
                else
                    phase = COMP_TAG;
            end else begin
                acc   = len;
                phase = COMP_DATA;
            end
        endfunction

        function int unsigned pending();
            return owed_verdicts.size();
        endfunction

        function void take_byte(tlvslv_pkg::in_item_t it);
            logic [7:0]            b;
            logic [LW-1:0]         wide_b;
            tlvslv_pkg::out_item_t e;
            b      = it.data_byte;
            wide_b = LW'(b);
            // once a verdict is out, everything up to the end of buffer is dropped
            if (verdict_done) begin
                if (it.end_of_buffer)
                    restart();
                return;
            end
            case (phase)
                WAIT_TAG: begin
                    if (b != tlvslv_pkg::HDR_TAG) settle(tlvslv_pkg::ERR_TAG);
                    else phase = WAIT_VERSION;
                end
                WAIT_VERSION: begin
                    if (b != tlvslv_pkg::HDR_VERSION) settle(tlvslv_pkg::ERR_VERSION);
                    else phase = SKIP_BYTE;
                end
                SKIP_BYTE: phase = TOTAL_LEN;
                TOTAL_LEN: begin
                    if ((b & LEN_LONG_BIT) != 0) begin
                        if (open_long(b)) phase = TOTAL_LONG;
                    end else begin
                        begin_walk(wide_b);
                    end
                end
                TOTAL_LONG: begin
                    if (!shift_in(wide_b)) begin
                        settle(tlvslv_pkg::ERR_WIDE);
                    end else begin
                        len_left--;
                        if (len_left == 0) begin_walk(acc);
                    end
                end
                COMP_TAG: begin
                    remaining--;
                    if (remaining == 0) settle(tlvslv_pkg::ERR_OVERRUN);
                    else phase = COMP_LEN;
                end
                COMP_LEN: begin
                    remaining--;
                    if ((b & LEN_LONG_BIT) != 0) begin
                        if (open_long(b)) begin
                            if (remaining < len_left) settle(tlvslv_pkg::ERR_OVERRUN);
                            else phase = COMP_LONG;
                        end
                    end else begin
                        close_len(wide_b);
                    end
                end
                COMP_LONG: begin
                    if (!shift_in(wide_b)) begin
                        settle(tlvslv_pkg::ERR_WIDE);
                    end else begin
                        remaining--;
                        len_left--;
                        if (len_left == 0) close_len(acc);
                    end
                end
                COMP_DATA: begin
                    remaining--;
                    acc--;
                    if (acc == 0) begin
                        if (remaining == 0) settle(tlvslv_pkg::ERR_OK);
                        else phase = COMP_TAG;
                    end
                end
                default: ;
            endcase
            if (!verdict_done) begin
                if (!it.end_of_buffer)
                    return;
                settle(tlvslv_pkg::ERR_TRUNC);
            end
            e.is_valid   = (verdict == tlvslv_pkg::ERR_OK);
            e.error_code = verdict;
            owed_verdicts.push_back(e);
            if (it.end_of_buffer)
                restart();
        endfunction

        function void check_verdict(tlvslv_pkg::out_item_t got);
            tlvslv_pkg::out_item_t e;
            if (owed_verdicts.size() == 0) begin
                $error("verdict with none owed: is_valid=%0d error_code=%0d",
                       got.is_valid, got.error_code);
                faults++;
                return;
            end
            e = owed_verdicts.pop_front();
            if (got.is_valid !== e.is_valid) begin
                $error("is_valid: expected %0d, actual %0d", e.is_valid, got.is_valid);
                faults++;
            end
            if (got.error_code !== e.error_code) begin
                $error("error_code: expected %0d, actual %0d", e.error_code, got.error_code);
                faults++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    tlvslv_pkg::in_item_t  s_data;
    logic                  m_valid;
    logic                  m_ready;
    tlvslv_pkg::out_item_t m_data;

    verdict_tracker_t board = new();
    int unsigned      bytes_taken;
    int unsigned      idle_cycles;
    int unsigned      burst_left;

    tlv_stream_length_validator DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // handshake monitor and stall watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                board.take_byte(s_data);
                bytes_taken++;
            end
            if (m_valid && m_ready)
                board.check_verdict(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("** tlv_stream_length_validator: FAILED **");
                $finish;
            end
        end
    end

    // result side: a randomly chosen stall pattern for each random span, plus one long hold
    initial begin
        sink_mode_t  mode;
        int unsigned span;
        int unsigned tick;
        bit          held;
        tick = 0;
        held = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            mode = sink_mode_t'($urandom_range(0, 3));
            span = $urandom_range(64, 256);
            repeat (span) begin
                @(negedge aclk);
                if (!held && bytes_taken >= HOLD_AFTER) begin
                    held = 1'b1;
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge aclk);
                end
                case (mode)
                    SINK_OPEN:    m_ready <= 1'b1;
                    SINK_COIN:    m_ready <= 1'($urandom_range(0, 1));
                    SINK_PULSE:   m_ready <= (tick % 4 == 0);
                    SINK_TRICKLE: m_ready <= ($urandom_range(0, 7) == 0);
                    default:      m_ready <= 1'b1;
                endcase
                tick++;
            end
        end
    end

    function automatic logic [7:0] rand_octet();
        logic [7:0] v;
        v = 8'($urandom);
        return v;
    endfunction

    // short form where it fits (unless forced long), else long form with optional zero padding
    function automatic void put_length(ref octet_q_t q, input logic [31:0] len,
                                       input bit go_long);
        int unsigned   need;
        int unsigned   n;
        logic [31:0]   part;
        if (!go_long && len < 128) begin
            q.push_back(len[7:0]);
            return;
        end
        need = (len < 32'h100) ? 1 : (len < 32'h1_0000) ? 2 : (len < 32'h100_0000) ? 3 : 4;
        n = need + $urandom_range(0, MLB - need);
        q.push_back(LEN_LONG_BIT | n[7:0]);
        for (int i = n - 1; i >= 0; i--) begin
            part = len >> (8 * i);
            q.push_back(part[7:0]);
        end
    endfunction

    // Mostly well-formed streams with random content; the rest are built with defects.
    // Returns the number of bytes that matter, leaving out the ignored tail.
    function automatic int unsigned build_stream(ref octet_q_t s);
        octet_q_t    body;
        int unsigned ncomp;
        int unsigned clen;
        int unsigned choice;
        int unsigned cut;
        int unsigned counted;
        logic [31:0] total;
        logic [7:0]  v;
        s.delete();
        ncomp = $urandom_range(0, 3);
        for (int c = 0; c < ncomp; c++) begin
            body.push_back(rand_octet());
            if ($urandom_range(0, 99) < 3) begin
                v = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(MLB + 1, 127));
                body.push_back(LEN_LONG_BIT | v);
                break;
            end
            clen = ($urandom_range(0, 19) == 0) ? $urandom_range(128, 300)
                                                 : $urandom_range(0, 8);
            put_length(body, clen, $urandom_range(0, 3) == 0);
            repeat (clen) body.push_back(rand_octet());
        end
        total  = body.size();
        choice = $urandom_range(0, 99);

        v = tlvslv_pkg::HDR_TAG;
        if (choice < 4) begin
            v = rand_octet();
            if (v == tlvslv_pkg::HDR_TAG) v = ~v;
        end
        s.push_back(v);
        v = tlvslv_pkg::HDR_VERSION;
        if (choice >= 4 && choice < 8) begin
            v = rand_octet();
            if (v == tlvslv_pkg::HDR_VERSION) v = v ^ 8'h01;
        end
        s.push_back(v);
        s.push_back(rand_octet());

        if (choice >= 60 && choice < 68)
            total = $urandom_range(0, total);
        else if (choice >= 68 && choice < 76)
            total = total + $urandom_range(1, 20);
        else if (choice >= 93 && choice < 97)
            total = $urandom | 32'h0100_0000;

        if (choice >= 89 && choice < 93) begin
            v = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(MLB + 1, 127));
            s.push_back(LEN_LONG_BIT | v);
        end else begin
            put_length(s, total, $urandom_range(0, 3) == 0);
        end

        if (choice >= 76 && choice < 81 && body.size() > 1) begin
            cut = $urandom_range(0, body.size() - 1);
            while (body.size() > cut) void'(body.pop_back());
        end
        foreach (body[i]) s.push_back(body[i]);

        if (choice >= 97) begin
            s.delete();
            repeat ($urandom_range(1, 10)) s.push_back(rand_octet());
        end
        counted = s.size();
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 4)) s.push_back(rand_octet());
        return counted;
    endfunction

    // Called at a falling edge; returns at a falling edge after acceptance, after an idle gap when a burst ends.
    task automatic offer(input tlvslv_pkg::in_item_t it);
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 250)
                                                      : $urandom_range(1, 10);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_stream(input octet_q_t s);
        tlvslv_pkg::in_item_t it;
        foreach (s[i]) begin
            it.data_byte     = s[i];
            it.end_of_buffer = (i == s.size() - 1);
            offer(it);
        end
    endtask

    initial begin
        octet_q_t    strm;
        int unsigned sent;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        bytes_taken = 0;
        idle_cycles = 0;
        burst_left  = 0;
        sent        = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // bad tag, bad version, zero total, early end, long count too wide
        send_stream('{8'h00});
        send_stream('{tlvslv_pkg::HDR_TAG, 8'h7f});
        send_stream('{tlvslv_pkg::HDR_TAG, tlvslv_pkg::HDR_VERSION, 8'hff, 8'h00});
        send_stream('{tlvslv_pkg::HDR_TAG});
        send_stream('{tlvslv_pkg::HDR_TAG, tlvslv_pkg::HDR_VERSION, 8'h00, 8'h85});
        // long-form total, one component ending exactly on the total
        send_stream('{tlvslv_pkg::HDR_TAG, tlvslv_pkg::HDR_VERSION, 8'h00, 8'h81, 8'h03,
                      8'hff, 8'h01, 8'hff});
        // total of one: the component tag already runs past it
        send_stream('{tlvslv_pkg::HDR_TAG, tlvslv_pkg::HDR_VERSION, 8'h00, 8'h01, 8'h04});

        while (sent < RANDOM_ITEMS) begin
            sent += build_stream(strm);
            send_stream(strm);
        end
        s_valid <= 1'b0;

        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.faults == 0 && board.pending() == 0)
            $display("** tlv_stream_length_validator: PASSED **");
        else
            $display("** tlv_stream_length_validator: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/tlvslv_pkg.sv
sv/tlvslv_in_stage.sv
sv/tlvslv_walker.sv
sv/tlv_stream_length_validator.sv
dv/tlv_stream_length_validator_tb.sv
